// ===== sv/btmx_pkg.sv =====
// Shared types and constants of the binary trie minimum-xor engine.
package btmx_pkg;

  // Widest key the engine supports; command values travel at this width.
  localparam int VALUE_W = 64;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_XOR    = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // What the back has to do with a command.
  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_INSERT,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [VALUE_W-1:0] value;  // insert key, or mask snapshot for a query
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_WALK,
    B_BUILD
  } back_state_t;

endpackage

// ===== sv/btmx_front.sv =====
// Front end: accepts items, keeps the xor mask and turns items into commands.
module btmx_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [1:0]           action,
  input  logic [31:0]          operand,
  input  btmx_pkg::back_status_t status,
  input  logic                 q_ready,
  output logic                 q_push,
  output btmx_pkg::cmd_t       q_cmd
);
  import btmx_pkg::*;

  logic [31:0] mask;
  logic [31:0] mask_next;

  assign item_ready = q_ready && !status.init_busy;
  assign q_push     = item_valid && item_ready;

  always_comb begin
    mask_next    = mask;
    q_cmd.kind   = CMD_PASS;
    q_cmd.value  = '0;
    case (action)
      ACT_INSERT: begin
        q_cmd.kind  = CMD_INSERT;
        q_cmd.value = VALUE_W'(operand ^ mask);
      end
      ACT_XOR: begin
        if (q_push) begin
          mask_next = mask ^ operand;
        end
      end
      ACT_QUERY: begin
        q_cmd.kind  = CMD_QUERY;
        q_cmd.value = VALUE_W'(mask);
      end
      default: begin
        q_cmd.kind = CMD_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

endmodule

// ===== sv/btmx_queue.sv =====
// Two-entry command queue between the front and the back.
module btmx_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  btmx_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output btmx_pkg::cmd_t pop_cmd
);
  import btmx_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign push_ready = (count != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/btmx_back.sv =====
// Back end: node memory, trie walk for insert and query, result register.
module btmx_back #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  btmx_pkg::cmd_t         cmd,
  output btmx_pkg::back_status_t status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [31:0]            answer,
  output logic                   dropped
);
  import btmx_pkg::*;

  localparam int LW         = $clog2(NODE_COUNT);
  localparam int CW         = LW + 2;
  localparam int LVW        = $clog2(KEY_BITS);
  localparam int XW         = (KEY_BITS > 32) ? KEY_BITS : 32;
  localparam int INIT_NODES = (KEY_BITS + 1 <= NODE_COUNT) ? KEY_BITS + 1 : 1;

  // node memory: {link1, link0}, link of zero means no child
  logic [2*LW-1:0] node_mem [NODE_COUNT];
  logic [2*LW-1:0] rd_data;
  logic [LW-1:0]   rd_addr;
  logic            wr_en;
  logic [LW-1:0]   wr_addr;
  logic [2*LW-1:0] wr_data;

  back_state_t         state, state_next;
  logic [LW:0]         init_idx, init_idx_next;
  logic [LW:0]         nodes_used, nodes_used_next;
  logic [LVW-1:0]      level, level_next;
  logic [LW-1:0]       node, node_next;
  logic                leaf, leaf_next;
  logic                is_query, is_query_next;
  logic [KEY_BITS-1:0] cur_key, cur_key_next;
  logic [KEY_BITS-1:0] ans, ans_next;
  logic                result_valid_next;
  logic [31:0]         answer_next;
  logic                dropped_next;

  logic [LW-1:0]       link0, link1, child, child_alt, new_link;
  logic                kb;
  logic                room_ok;
  logic [KEY_BITS-1:0] low_mask;
  logic [KEY_BITS-1:0] ans_upd;
  logic [XW-1:0]       ans_ext;
  logic                out_free;
  logic                out_load;
  logic [31:0]         out_answer;
  logic                out_drop;
  logic                finish_walk;

  assign link0    = rd_data[LW-1:0];
  assign link1    = rd_data[2*LW-1:LW];
  assign kb       = cur_key[level];
  assign new_link = nodes_used[LW-1:0];
  assign room_ok  = (CW'(nodes_used) + CW'(level) + CW'(1)) <= CW'(NODE_COUNT);
  assign out_free = !result_valid || result_ready;
  assign status.init_busy = (state == B_INIT);

  always_comb begin
    for (int j = 0; j < KEY_BITS; j++) begin
      low_mask[j] = (j <= int'(level));
    end
  end

  always_comb begin
    state_next      = state;
    init_idx_next   = init_idx;
    nodes_used_next = nodes_used;
    level_next      = level;
    node_next       = node;
    leaf_next       = leaf;
    is_query_next   = is_query;
    cur_key_next    = cur_key;
    ans_next        = ans;
    cmd_ready       = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = node;
    wr_data         = '0;
    out_load        = 1'b0;
    out_answer      = '0;
    out_drop        = 1'b0;
    finish_walk     = 1'b0;
    child           = kb ? link1 : link0;
    child_alt       = kb ? link0 : link1;
    ans_upd         = ans;

    case (state)
      B_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_idx[LW-1:0];
        if (init_idx < (LW + 1)'(INIT_NODES - 1)) begin
          wr_data = {LW'(0), LW'(init_idx + 1'b1)};
        end
        init_idx_next = init_idx + 1'b1;
        if (init_idx == (LW + 1)'(INIT_NODES - 1)) begin
          state_next = B_IDLE;
        end
      end

      B_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          case (cmd.kind)
            CMD_INSERT, CMD_QUERY: begin
              is_query_next = (cmd.kind == CMD_QUERY);
              cur_key_next  = cmd.value[KEY_BITS-1:0];
              node_next     = '0;
              rd_addr       = '0;
              level_next    = LVW'(KEY_BITS - 1);
              ans_next      = '0;
              state_next    = B_WALK;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      B_WALK: begin
        if (is_query) begin
          if (child != '0) begin
            node_next = child;
          end else if (child_alt != '0) begin
            ans_upd   = ans | (KEY_BITS'(1) << level);
            child     = child_alt;
            node_next = child_alt;
          end else begin
            ans_upd     = ans | low_mask;
            finish_walk = 1'b1;
          end
          ans_next = ans_upd;
          if (level == '0) begin
            finish_walk = 1'b1;
          end
          if (finish_walk) begin
            out_load   = 1'b1;
            out_answer = ans_ext[31:0];
            state_next = B_IDLE;
          end else begin
            rd_addr    = child;
            level_next = level - 1'b1;
          end
        end else begin
          if (child != '0) begin
            if (level == '0) begin
              out_load   = 1'b1;
              state_next = B_IDLE;
            end else begin
              node_next  = child;
              rd_addr    = child;
              level_next = level - 1'b1;
            end
          end else if (!room_ok) begin
            out_load   = 1'b1;
            out_drop   = 1'b1;
            state_next = B_IDLE;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = node;
            wr_data         = kb ? {new_link, link0} : {link1, new_link};
            node_next       = new_link;
            nodes_used_next = nodes_used + 1'b1;
            if (level == '0) begin
              leaf_next = 1'b1;
            end else begin
              leaf_next  = 1'b0;
              level_next = level - 1'b1;
            end
            state_next = B_BUILD;
          end
        end
      end

      B_BUILD: begin
        wr_en   = 1'b1;
        wr_addr = node;
        if (leaf) begin
          wr_data    = '0;
          out_load   = 1'b1;
          state_next = B_IDLE;
        end else begin
          wr_data         = kb ? {new_link, LW'(0)} : {LW'(0), new_link};
          node_next       = new_link;
          nodes_used_next = nodes_used + 1'b1;
          if (level == '0) begin
            leaf_next = 1'b1;
          end else begin
            level_next = level - 1'b1;
          end
        end
      end

      default: begin
        state_next = B_INIT;
      end
    endcase
  end

  assign ans_ext = XW'(ans_upd);

  always_comb begin
    result_valid_next = result_valid && !result_ready;
    answer_next       = answer;
    dropped_next      = dropped;
    if (out_load) begin
      result_valid_next = 1'b1;
      answer_next       = out_answer;
      dropped_next      = out_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    rd_data <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_INIT;
      init_idx     <= '0;
      nodes_used   <= (LW + 1)'(INIT_NODES);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      init_idx     <= init_idx_next;
      nodes_used   <= nodes_used_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    level    <= level_next;
    node     <= node_next;
    leaf     <= leaf_next;
    is_query <= is_query_next;
    cur_key  <= cur_key_next;
    ans      <= ans_next;
    answer   <= answer_next;
    dropped  <= dropped_next;
  end

endmodule

// ===== sv/binary_trie_min_xor_engine.sv =====
// Binary trie minimum-xor engine. Keeps a trie of KEY_BITS-bit keys in a
// NODE_COUNT-entry node memory plus a running 32-bit xor mask. Action 0
// inserts operand^mask, action 1 folds operand into the mask, action 2
// returns the least (stored key ^ mask); every transaction in gives exactly
// one transaction out. An insert that would need more free nodes than remain
// is dropped whole and reported with dropped=1. The front accepts items,
// applies mask updates and queues commands in a two-entry queue; the back
// walks the trie through a single-port node memory with registered read, one
// trie level per cycle; an insert that builds a new path ends with a leaf
// write. Mask updates and unused actions only load the result register.
// After reset the block writes the key-zero path into the node memory, one
// node per cycle, with item_ready low; the result register holds a finished
// result while the front keeps taking items until the queue is full.
module binary_trie_min_xor_engine #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  action,
  input  logic [31:0] operand,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] answer,
  output logic        dropped
);
  import btmx_pkg::*;

  back_status_t status;
  cmd_t         push_cmd;
  cmd_t         pop_cmd;
  logic         q_push;
  logic         q_ready;
  logic         pop_valid;
  logic         pop_ready;

  // front: handshake, mask register, command classification
  btmx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (action),
    .operand    (operand),
    .status     (status),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  // decouples front from the multi-cycle trie walk
  btmx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: node memory, init pass, walk sequencer, result register
  btmx_back #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (pop_valid),
    .cmd_ready    (pop_ready),
    .cmd          (pop_cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .answer       (answer),
    .dropped      (dropped)
  );

endmodule

// ===== sv/btmx_checker.sv =====
// Port-level checks for the binary trie minimum-xor engine, bound to the top.
module btmx_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] answer,
  input logic        dropped
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(answer) && $stable(dropped))
    else $error("result changed while stalled");

  // a dropped insert never carries an answer
  a_drop_no_answer: assert property (@(posedge clk) disable iff (rst)
    result_valid && dropped |-> answer == 32'd0)
    else $error("dropped result with nonzero answer");

  // the node memory init pass keeps the input closed right after reset
  a_init_closed: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("item accepted during init pass");

  // no result is pending after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind binary_trie_min_xor_engine btmx_checker u_btmx_checker (.*);
